// ----- rtl/tps_pkg.sv -----
// Shared types and constants for the truncated Poisson sampler.
// No dependencies; imported by truncated_poisson_sampler_core.

package tps_pkg;

    // Field widths of the request and result channels.
    localparam int LAMBDA_W   = 16;
    localparam int UNIFORM_W  = 32;
    localparam int CATEGORY_W = 5;
    localparam int LIMIT_W    = 4;

    // Reset value of the upper limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

    // Weights are unsigned Q54.10 in 64 bits.
    localparam int WEIGHT_W    = 64;
    localparam int HALF_W      = WEIGHT_W / 2;
    localparam int LAMBDA_FRAC = 10;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 64'd1 << LAMBDA_FRAC;

    // Rounding constant for the ceiling in the target scaling.
    localparam logic [WEIGHT_W-1:0] ROUND_UP = 64'h0000_0000_FFFF_FFFF;

    // The small divider retires this many quotient bits per cycle.
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = WEIGHT_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_MUL_LO  = 11'b000_0000_0010,
        S_MUL_HI  = 11'b000_0000_0100,
        S_SUM     = 11'b000_0000_1000,
        S_DIV     = 11'b000_0001_0000,
        S_STORE   = 11'b000_0010_0000,
        S_TGT_LO  = 11'b000_0100_0000,
        S_TGT_HI  = 11'b000_1000_0000,
        S_TGT_SUM = 11'b001_0000_0000,
        S_SCAN    = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

endpackage

// ----- rtl/truncated_poisson_sampler_core.sv -----
// Upper-truncated Poisson sampler by inverse CDF, one shared multiplier and
// a small radix-256 divider under a sequencer. Depends on tps_pkg.
//
//   channel   signals                       direction   payload
//   request   in_valid / in_stall           in          lambda, uniform
//   result    out_valid / out_stall         out         category
//   config    cfg_wr_en                     in          cfg_wr_data (upper_limit)
//
// Each weight after the first needs two passes through the shared 32x32
// multiplier, one add, and a run of the divider that retires eight quotient
// bits per cycle; the scan then walks the categories in order until the
// running sum of weights reaches the target or the last category is reached.
// Reset sets upper_limit to 8 and leaves the sampler idle with no result.
// A new request is taken while an earlier result still waits on out_stall;
// the next result is held inside until the output register is free.

module truncated_poisson_sampler_core #(
    parameter int MAX_CATEGORIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tps_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tps_pkg::LAMBDA_W-1:0]    lambda,
    input  logic [tps_pkg::UNIFORM_W-1:0]   uniform,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tps_pkg::CATEGORY_W-1:0]  category
);

    import tps_pkg::*;

    localparam int IDX_W = $clog2(MAX_CATEGORIES);
    localparam int CNT_W = $clog2(MAX_CATEGORIES + 1);

    // Control registers.
    state_t                 state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Payload registers.
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [LAMBDA_W-1:0]    lam_reg, lam_next;
    logic [UNIFORM_W-1:0]   u_reg, u_next;
    logic [WEIGHT_W-1:0]    w_reg, w_next;
    logic [WEIGHT_W-1:0]    s_reg, s_next;
    logic [WEIGHT_W-1:0]    t_reg, t_next;
    logic [WEIGHT_W-1:0]    c_reg, c_next;
    logic [WEIGHT_W-1:0]    dq_reg, dq_next;
    logic [IDX_W-1:0]       rem_reg, rem_next;
    logic [WEIGHT_W-1:0]    mul_reg;
    logic [CATEGORY_W-1:0]  category_reg, category_next;

    // Weight store, one entry per category.
    logic [WEIGHT_W-1:0]    wt_mem [MAX_CATEGORIES];
    logic                   wt_wr_en;
    logic [IDX_W-1:0]       wt_wr_idx;
    logic [WEIGHT_W-1:0]    wt_wr_data;
    logic [WEIGHT_W-1:0]    wt_rd_reg;

    // Shared multiplier operands.
    logic [HALF_W-1:0]      mul_a;
    logic [HALF_W-1:0]      mul_b;

    // Helper values.
    logic                   req_accept;
    logic [LIMIT_W:0]       n_full;
    logic [WEIGHT_W-1:0]    scan_sum;
    logic                   scan_hit;
    logic                   scan_last;
    logic                   weight_last;
    logic                   out_free;
    logic [WEIGHT_W-1:0]    div_dq;
    logic [IDX_W-1:0]       div_rem;

    assign req_accept = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign category   = category_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Number of categories for a new request, clamped later to the storage depth.
    assign n_full = (LIMIT_W + 1)'(limit_reg) + (LIMIT_W + 1)'(1);

    assign weight_last = (CNT_W'(j_reg) == n_reg - CNT_W'(1));
    assign scan_last   = (CNT_W'(k_reg) == n_reg - CNT_W'(1));
    assign scan_sum    = c_reg + wt_rd_reg;
    assign scan_hit    = (scan_sum >= t_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = w_reg[HALF_W-1:0];
        mul_b = HALF_W'(lam_reg);
        case (state_reg)
            S_MUL_HI:
            begin
                mul_a = w_reg[WEIGHT_W-1:HALF_W];
            end
            S_TGT_LO:
            begin
                mul_a = s_reg[HALF_W-1:0];
                mul_b = u_reg;
            end
            S_TGT_HI:
            begin
                mul_a = s_reg[WEIGHT_W-1:HALF_W];
                mul_b = u_reg;
            end
            default:
            begin
                mul_a = w_reg[HALF_W-1:0];
                mul_b = HALF_W'(lam_reg);
            end
        endcase
    end

    // Long division by the category index, eight quotient bits per cycle.
    // The remainder stays below the divisor, so each step is narrow.
    always_comb
    begin
        logic [IDX_W:0]      trial;
        logic [WEIGHT_W-1:0] dq;
        logic [IDX_W-1:0]    rem;
        dq  = dq_reg;
        rem = rem_reg;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            trial = {rem, dq[WEIGHT_W-1]};
            dq    = {dq[WEIGHT_W-2:0], 1'b0};
            if (trial >= {1'b0, j_reg})
            begin
                rem   = IDX_W'(trial - {1'b0, j_reg});
                dq[0] = 1'b1;
            end
            else
            begin
                rem = trial[IDX_W-1:0];
            end
        end
        div_dq  = dq;
        div_rem = rem;
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        div_cnt_next   = div_cnt_reg;
        n_next         = n_reg;
        lam_next       = lam_reg;
        u_next         = u_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        c_next         = c_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        category_next  = category_reg;
        wt_wr_en       = 1'b0;
        wt_wr_idx      = j_reg;
        wt_wr_data     = dq_reg;

        // The result register drains independently of the sequencer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    lam_next   = lambda;
                    u_next     = uniform;
                    w_next     = WEIGHT_ONE;
                    s_next     = WEIGHT_ONE;
                    j_next     = IDX_W'(1);
                    wt_wr_en   = 1'b1;
                    wt_wr_idx  = '0;
                    wt_wr_data = WEIGHT_ONE;
                    if (n_full > (LIMIT_W + 1)'(MAX_CATEGORIES))
                    begin
                        n_next = CNT_W'(MAX_CATEGORIES);
                    end
                    else
                    begin
                        n_next = CNT_W'(n_full);
                    end
                    // A single category needs no weights beyond the first.
                    if (n_full == (LIMIT_W + 1)'(1))
                    begin
                        state_next = S_TGT_LO;
                    end
                    else
                    begin
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                // Low product already shifted down by the fraction bits.
                dq_next    = {{LAMBDA_FRAC{1'b0}}, mul_reg[WEIGHT_W-1:LAMBDA_FRAC]};
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // High product lands 22 bits up; the sum wraps at 64 bits.
                dq_next      = {mul_reg[WEIGHT_W-HALF_W+LAMBDA_FRAC-1:0],
                                {(HALF_W-LAMBDA_FRAC){1'b0}}} + dq_reg;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                dq_next      = div_dq;
                rem_next     = div_rem;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                w_next     = dq_reg;
                s_next     = s_reg + dq_reg;
                wt_wr_en   = 1'b1;
                wt_wr_idx  = j_reg;
                wt_wr_data = dq_reg;
                if (weight_last)
                begin
                    state_next = S_TGT_LO;
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_MUL_LO;
                end
            end
            S_TGT_LO:
            begin
                state_next = S_TGT_HI;
            end
            S_TGT_HI:
            begin
                // Ceiling of the low partial product over 2^32.
                t_next     = (mul_reg + ROUND_UP) >> HALF_W;
                state_next = S_TGT_SUM;
            end
            S_TGT_SUM:
            begin
                t_next     = mul_reg + t_reg;
                c_next     = '0;
                k_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                c_next = scan_sum;
                // The last category is taken when no earlier one reaches the target.
                if (scan_hit || scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    category_next  = CATEGORY_W'(k_reg) + CATEGORY_W'(1);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            div_cnt_reg   <= div_cnt_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers and the shared multiplier output.
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        lam_reg      <= lam_next;
        u_reg        <= u_next;
        w_reg        <= w_next;
        s_reg        <= s_next;
        t_reg        <= t_next;
        c_reg        <= c_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        category_reg <= category_next;
        mul_reg      <= mul_a * mul_b;
    end

    // Weight store. The read port follows the next scan index, so the entry
    // for the current scan step is already registered when it is needed.
    always_ff @(posedge clk)
    begin
        if (wt_wr_en)
        begin
            wt_mem[wt_wr_idx] <= wt_wr_data;
        end
        wt_rd_reg <= wt_mem[k_next];
    end

endmodule
